// ===== hw/rtl/dids_pkg.sv =====
`default_nettype none
package dids_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int WORD_CAP    = 3 * MAX_ENTRIES;

   localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
   localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
   localparam int WORD_AW  = $clog2(WORD_CAP);
   localparam int WCNT_W   = $clog2(WORD_CAP + 1);

   localparam int ID_W  = 64;
   localparam int OFF_W = 63;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_FINISH = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_WORDS = 3'd1,
      ST_BAD_RANGE = 3'd2,
      ST_OVER_CAP  = 3'd3,
      ST_NO_INDEX  = 3'd4
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/dids_word_store.sv =====
`default_nettype none
module dids_word_store
   import dids_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [WORD_AW-1:0] wr_addr,
   input  wire logic [ID_W-1:0]    wr_data,
   input  wire logic [WORD_AW-1:0] rd_addr,
   output logic      [ID_W-1:0]    rd_data
);

   logic [ID_W-1:0] mem [WORD_CAP];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/dids_entry_store.sv =====
`default_nettype none
module dids_entry_store
   import dids_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ENTRY_AW-1:0] wr_addr,
   input  wire logic [ID_W-1:0]     wr_id,
   input  wire logic [OFF_W-1:0]    wr_start,
   input  wire logic [OFF_W-1:0]    wr_end,
   input  wire logic [ENTRY_AW-1:0] rd_addr,
   output logic      [ID_W-1:0]     rd_id,
   output logic      [OFF_W-1:0]    rd_start,
   output logic      [OFF_W-1:0]    rd_end
);

   logic [ID_W-1:0]  ids    [MAX_ENTRIES];
   logic [OFF_W-1:0] starts [MAX_ENTRIES];
   logic [OFF_W-1:0] ends   [MAX_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ids[wr_addr]    <= wr_id;
         starts[wr_addr] <= wr_start;
         ends[wr_addr]   <= wr_end;
      end
      rd_id    <= ids[rd_addr];
      rd_start <= starts[rd_addr];
      rd_end   <= ends[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/delta_index_decode_sort_lookup_top.sv =====
`default_nettype none
// delta-coded index decoder with sorted lookup
// input channel: a transaction is taken when start is high and busy is low;
//   req_command selects load word, finish/decode, or lookup
// result channel: rsp_valid marks each result for one cycle; the receiver
//   cannot hold results off, rsp_last flags the final result of a run
// load: taken with busy staying low, no result
// finish: error cases and an empty index answer in the next cycle;
//   otherwise each entry fetches its three column words through the
//   shared adder (RD_ID, GAP, SIZE, CHK), a bad range ending the run,
//   then is inserted by shifting larger entries up one slot at a time
//   (INS, INS_CMP); then entries are emitted in order (EMIT_RD, EMIT_OUT)
// lookup: binary search, each halving step a read (LK_RD) then a compare
//   (LK_CMP) on the one entry store read port, then LK_FIN answers
// ignored command 3 gives no result
// reset: synchronous, clears word count, overflow and index valid; stores
//   themselves are not cleared, no clearing pass
module delta_index_decode_sort_lookup_top
   import dids_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [1:0]       req_command,
   input  wire logic [ID_W-1:0]  req_index_word,
   input  wire logic [ID_W-1:0]  req_lookup_key,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic                  rsp_found,
   output logic [ID_W-1:0]       rsp_chunk_ident,
   output logic [OFF_W-1:0]      rsp_range_start,
   output logic [OFF_W-1:0]      rsp_range_end,
   output logic                  rsp_last
);

   typedef enum logic [3:0] {
      S_IDLE, S_RD_ID, S_GAP, S_SIZE, S_CHK, S_INS, S_INS_CMP,
      S_EMIT_RD, S_EMIT_OUT, S_LK_RD, S_LK_CMP, S_LK_FIN
   } state_type;

   state_type state_ff, state_in;

   // load side counters
   logic [WCNT_W-1:0]  wc_ff, wc_in;
   logic [1:0]         mod_ff, mod_in;
   logic [CNT_W-1:0]   div_ff, div_in;
   logic               ovf_ff, ovf_in;
   // kept index
   logic               valid_ff, valid_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   // decode walk
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [WORD_AW-1:0] ptr_gap_ff, ptr_gap_in;
   logic [WORD_AW-1:0] ptr_size_ff, ptr_size_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [ID_W-1:0]    off_ff, off_in;
   logic [ID_W-1:0]    start_ff, start_in;
   // search
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [ID_W-1:0]    key_ff, key_in;
   // result register
   logic               rv_ff, rv_in;
   logic [2:0]         rst_ff, rst_in;
   logic               rf_ff, rf_in;
   logic [ID_W-1:0]    rid_ff, rid_in;
   logic [OFF_W-1:0]   rs_ff, rs_in;
   logic [OFF_W-1:0]   re_ff, re_in;
   logic               rl_ff, rl_in;

   logic               accept;
   logic               raw_we;
   logic [WORD_AW-1:0] raw_raddr;
   logic [ID_W-1:0]    raw_rdata;
   logic               ent_we;
   logic               ent_wsel_rd;
   logic [ENTRY_AW-1:0] ent_waddr;
   logic [ENTRY_AW-1:0] ent_raddr;
   logic [ID_W-1:0]    ent_rid;
   logic [OFF_W-1:0]   ent_rstart;
   logic [OFF_W-1:0]   ent_rend;
   logic [ID_W-1:0]    add_a;
   logic [ID_W-1:0]    add_sum;
   logic [CNT_W-1:0]   i_next;
   logic [CNT_W-1:0]   mid_calc;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign raw_we = accept && (cmd_type'(req_command) == CMD_LOAD)
                   && (wc_ff != WCNT_W'(WORD_CAP));

   // shared 64-bit adder: id prefix sum in the gap step, offset chain otherwise
   assign add_a   = (state_ff == S_GAP) ? id_ff : off_ff;
   assign add_sum = add_a + raw_rdata;
   assign i_next  = i_ff + CNT_W'(1);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);

   dids_word_store u_words (
      .clock   (clock),
      .wr_en   (raw_we),
      .wr_addr (wc_ff[WORD_AW-1:0]),
      .wr_data (req_index_word),
      .rd_addr (raw_raddr),
      .rd_data (raw_rdata)
   );

   dids_entry_store u_entries (
      .clock    (clock),
      .wr_en    (ent_we),
      .wr_addr  (ent_waddr),
      .wr_id    (ent_wsel_rd ? ent_rid : id_ff),
      .wr_start (ent_wsel_rd ? ent_rstart : start_ff[OFF_W-1:0]),
      .wr_end   (ent_wsel_rd ? ent_rend : off_ff[OFF_W-1:0]),
      .rd_addr  (ent_raddr),
      .rd_id    (ent_rid),
      .rd_start (ent_rstart),
      .rd_end   (ent_rend)
   );

   always_comb begin
      state_in    = state_ff;
      wc_in       = wc_ff;
      mod_in      = mod_ff;
      div_in      = div_ff;
      ovf_in      = ovf_ff;
      valid_in    = valid_ff;
      count_in    = count_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      ptr_gap_in  = ptr_gap_ff;
      ptr_size_in = ptr_size_ff;
      id_in       = id_ff;
      off_in      = off_ff;
      start_in    = start_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      key_in      = key_ff;
      rv_in       = 1'b0;
      rst_in      = rst_ff;
      rf_in       = rf_ff;
      rid_in      = rid_ff;
      rs_in       = rs_ff;
      re_in       = re_ff;
      rl_in       = rl_ff;
      raw_raddr   = WORD_AW'(i_ff);
      ent_we      = 1'b0;
      ent_wsel_rd = 1'b0;
      ent_waddr   = j_ff[ENTRY_AW-1:0];
      ent_raddr   = i_ff[ENTRY_AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_command))
                  CMD_LOAD: begin
                     if (wc_ff == WCNT_W'(WORD_CAP)) begin
                        ovf_in = 1'b1;
                     end else begin
                        wc_in = wc_ff + WCNT_W'(1);
                        if (mod_ff == 2'd2) begin
                           mod_in = 2'd0;
                           div_in = div_ff + CNT_W'(1);
                        end else begin
                           mod_in = mod_ff + 2'd1;
                        end
                     end
                  end
                  CMD_FINISH: begin
                     wc_in    = '0;
                     mod_in   = '0;
                     div_in   = '0;
                     ovf_in   = 1'b0;
                     valid_in = 1'b0;
                     count_in = '0;
                     rf_in    = 1'b0;
                     rid_in   = '0;
                     rs_in    = '0;
                     re_in    = '0;
                     rl_in    = 1'b1;
                     rst_in   = ST_OK;
                     if (ovf_ff) begin
                        rv_in  = 1'b1;
                        rst_in = ST_OVER_CAP;
                     end else if (mod_ff != 2'd0) begin
                        rv_in  = 1'b1;
                        rst_in = ST_BAD_WORDS;
                     end else if (div_ff == '0) begin
                        // empty index is valid
                        rv_in    = 1'b1;
                        valid_in = 1'b1;
                     end else begin
                        n_in        = div_ff;
                        i_in        = '0;
                        id_in       = '0;
                        off_in      = '0;
                        ptr_gap_in  = WORD_AW'(div_ff);
                        ptr_size_in = WORD_AW'(div_ff) + WORD_AW'(div_ff);
                        state_in    = S_RD_ID;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (!valid_ff) begin
                        rv_in  = 1'b1;
                        rst_in = ST_NO_INDEX;
                        rf_in  = 1'b0;
                        rid_in = '0;
                        rs_in  = '0;
                        re_in  = '0;
                        rl_in  = 1'b1;
                     end else begin
                        key_in   = req_lookup_key;
                        lo_in    = '0;
                        hi_in    = count_ff;
                        state_in = S_LK_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD_ID: begin
            raw_raddr = WORD_AW'(i_ff);
            state_in  = S_GAP;
         end
         S_GAP: begin
            id_in     = add_sum;
            raw_raddr = ptr_gap_ff;
            state_in  = S_SIZE;
         end
         S_SIZE: begin
            off_in    = add_sum;
            start_in  = add_sum;
            raw_raddr = ptr_size_ff;
            state_in  = S_CHK;
         end
         S_CHK: begin
            off_in = add_sum;
            if (start_ff[ID_W-1] || ($signed(start_ff) > $signed(add_sum))) begin
               rv_in    = 1'b1;
               rst_in   = ST_BAD_RANGE;
               rf_in    = 1'b0;
               rid_in   = id_ff;
               rs_in    = '0;
               re_in    = '0;
               rl_in    = 1'b1;
               state_in = S_IDLE;
            end else begin
               j_in        = i_ff;
               ptr_gap_in  = ptr_gap_ff + WORD_AW'(1);
               ptr_size_in = ptr_size_ff + WORD_AW'(1);
               state_in    = S_INS;
            end
         end
         S_INS: begin
            if (j_ff == '0) begin
               ent_we    = 1'b1;
               ent_waddr = '0;
               i_in      = i_next;
               if (i_next == n_ff) begin
                  valid_in = 1'b1;
                  count_in = n_ff;
                  i_in     = '0;
                  state_in = S_EMIT_RD;
               end else begin
                  state_in = S_RD_ID;
               end
            end else begin
               ent_raddr = ENTRY_AW'(j_ff - CNT_W'(1));
               state_in  = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            ent_we    = 1'b1;
            ent_waddr = j_ff[ENTRY_AW-1:0];
            if (ent_rid > id_ff) begin
               // shift the larger entry up one place
               ent_wsel_rd = 1'b1;
               j_in        = j_ff - CNT_W'(1);
               state_in    = S_INS;
            end else begin
               i_in = i_next;
               if (i_next == n_ff) begin
                  valid_in = 1'b1;
                  count_in = n_ff;
                  i_in     = '0;
                  state_in = S_EMIT_RD;
               end else begin
                  state_in = S_RD_ID;
               end
            end
         end
         S_EMIT_RD: begin
            ent_raddr = i_ff[ENTRY_AW-1:0];
            state_in  = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            rv_in  = 1'b1;
            rst_in = ST_OK;
            rf_in  = 1'b1;
            rid_in = ent_rid;
            rs_in  = ent_rstart;
            re_in  = ent_rend;
            rl_in  = (i_next == count_ff);
            i_in   = i_next;
            state_in = (i_next == count_ff) ? S_IDLE : S_EMIT_RD;
         end
         S_LK_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in    = mid_calc;
               ent_raddr = mid_calc[ENTRY_AW-1:0];
               state_in  = S_LK_CMP;
            end else begin
               ent_raddr = lo_ff[ENTRY_AW-1:0];
               state_in  = S_LK_FIN;
            end
         end
         S_LK_CMP: begin
            if (ent_rid < key_ff) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_LK_RD;
         end
         S_LK_FIN: begin
            rv_in  = 1'b1;
            rst_in = ST_OK;
            rid_in = key_ff;
            rl_in  = 1'b1;
            if ((lo_ff < count_ff) && (ent_rid == key_ff)) begin
               rf_in = 1'b1;
               rs_in = ent_rstart;
               re_in = ent_rend;
            end else begin
               rf_in = 1'b0;
               rs_in = '0;
               re_in = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wc_ff    <= '0;
         mod_ff   <= '0;
         div_ff   <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         wc_ff    <= wc_in;
         mod_ff   <= mod_in;
         div_ff   <= div_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      ptr_gap_ff  <= ptr_gap_in;
      ptr_size_ff <= ptr_size_in;
      id_ff       <= id_in;
      off_ff      <= off_in;
      start_ff    <= start_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      rst_ff      <= rst_in;
      rf_ff       <= rf_in;
      rid_ff      <= rid_in;
      rs_ff       <= rs_in;
      re_ff       <= re_in;
      rl_ff       <= rl_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = rst_ff;
   assign rsp_found       = rf_ff;
   assign rsp_chunk_ident = rid_ff;
   assign rsp_range_start = rs_ff;
   assign rsp_range_end   = re_ff;
   assign rsp_last        = rl_ff;

   // a run that continues carries good entries only
   a_mid_run_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_found && (rsp_status == ST_OK)))
      else $error("non-final result without an entry");

   // a hit never carries an inverted range
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_range_start <= rsp_range_end))
      else $error("range start above end");

   // a load transaction never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_LOAD)) |=> !rsp_valid)
      else $error("result after load");

   // word count stays within the store
   a_word_cap: assert property (@(posedge clock) disable iff (reset)
      (wc_ff <= WCNT_W'(WORD_CAP)))
      else $error("word count past capacity");

endmodule
`default_nettype wire
